### src/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types and constants of the flat point selector: field widths,
// register indexes, register reset values and curvature limits.
// ----------------------------------------------------------------------------
package lfps_pkg;

	// fixed field widths
	localparam int CURV_WIDTH   = 54;
	localparam int INTEN_WIDTH  = 16;
	localparam int STRIDE_WIDTH = 8;
	localparam int FILL_WIDTH   = 3;

	// window depth held in registers (the fifth point is the incoming one)
	localparam int WIN_DEPTH = 4;
	localparam int AXES      = 3;

	// second difference magnitudes below two to this power are squared exactly
	localparam int SQ_IN_MAX = 27;

	// a squared term that overflows is forced to the curvature limit plus one
	localparam int TERM_WIDTH = CURV_WIDTH + 1;
	localparam int SUM_WIDTH  = CURV_WIDTH + 3;

	localparam logic [CURV_WIDTH-1:0] CURV_MAX = {CURV_WIDTH{1'b1}};

	// register reset values
	localparam logic [CURV_WIDTH-1:0]   THRESH_RESET = 54'd1049;
	localparam logic [STRIDE_WIDTH-1:0] STRIDE_RESET = 8'd1;

	// window fill level at which evaluation starts
	localparam logic [FILL_WIDTH-1:0] FILL_FULL = 3'd4;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_CURV_THRESHOLD = 1'b0,
		REG_SAMPLE_STRIDE  = 1'b1
	} cfg_reg_t;

endpackage

### src/lfps_point_if.sv
// ----------------------------------------------------------------------------
// lfps_point_if / lfps_feature_if
// Valid/ready channels of the flat point selector: incoming lidar points and
// outgoing flat feature points.
// ----------------------------------------------------------------------------
interface lfps_point_if
	import lfps_pkg::*;
#(
	parameter int COORD_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;
	logic [INTEN_WIDTH-1:0]        intensity;
	logic                          point_valid;
	logic                          frame_start;

	modport source (
		output valid, point_x, point_y, point_z, intensity, point_valid, frame_start,
		input  ready
	);

	modport sink (
		input  valid, point_x, point_y, point_z, intensity, point_valid, frame_start,
		output ready
	);
endinterface

interface lfps_feature_if
	import lfps_pkg::*;
#(
	parameter int COORD_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] feature_x;
	logic signed [COORD_WIDTH-1:0] feature_y;
	logic signed [COORD_WIDTH-1:0] feature_z;
	logic [INTEN_WIDTH-1:0]        feature_intensity;
	logic [CURV_WIDTH-1:0]         curvature;

	modport source (
		output valid, feature_x, feature_y, feature_z, feature_intensity, curvature,
		input  ready
	);

	modport sink (
		input  valid, feature_x, feature_y, feature_z, feature_intensity, curvature,
		output ready
	);
endinterface

### src/lidar_flat_point_selector.sv
// Pipeline: an accepted point passes the stage 1 and stage 2 registers, then the output register.
// Throughput: one point per cycle; the three pipeline stages advance together and
// stall only while the output register holds an item that is not taken.
// Reset: window cleared, window fill and stride counters cleared, threshold 1049,
// stride 1; no clearing pass, points are accepted right after reset.
// ----------------------------------------------------------------------------
// lidar_flat_point_selector
// Five-point curvature test on a lidar point stream; emits the centre point
// of each sampled window whose curvature is below the threshold.
// ----------------------------------------------------------------------------
module lidar_flat_point_selector
	import lfps_pkg::*;
#(
	parameter int COORD_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_reg_t              cfg_index,
	input  logic [CURV_WIDTH-1:0] cfg_data,
	lfps_point_if.sink            points,
	lfps_feature_if.source        features
);

	// second difference width and magnitude width
	localparam int DW = COORD_WIDTH + 3;
	localparam int AW = COORD_WIDTH + 2;
	localparam int MW = (AW < SQ_IN_MAX) ? AW : SQ_IN_MAX;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DW-1:0]          diff_t;

	function automatic diff_t second_diff(input coord_t a, input coord_t b,
		input coord_t c, input coord_t d, input coord_t e);
		diff_t c4;
		c4 = DW'(c) <<< 2;
		return DW'(a) + DW'(b) - c4 + DW'(d) + DW'(e);
	endfunction

	// configuration registers
	logic [CURV_WIDTH-1:0]   thresh_q;
	logic [STRIDE_WIDTH-1:0] stride_q;

	// window state
	coord_t                 win_q [AXES][WIN_DEPTH];
	logic [INTEN_WIDTH-1:0] win_inten_q [WIN_DEPTH];
	logic [FILL_WIDTH-1:0]  fill_q;
	logic [STRIDE_WIDTH-1:0] cnt_q;

	// pipeline registers
	logic                   valid_s1;
	diff_t                  diff_s1 [AXES];
	coord_t                 centre_s1 [AXES];
	logic [INTEN_WIDTH-1:0] inten_s1;

	logic                   valid_s2;
	logic [TERM_WIDTH-1:0]  term_s2 [AXES];
	coord_t                 centre_s2 [AXES];
	logic [INTEN_WIDTH-1:0] inten_s2;

	logic                   out_valid_q;
	coord_t                 out_pt_q [AXES];
	logic [INTEN_WIDTH-1:0] out_inten_q;
	logic [CURV_WIDTH-1:0]  out_curv_q;

	// handshake
	logic advance;
	logic accept;

	assign advance      = !out_valid_q || features.ready;
	assign accept       = points.valid && advance;
	assign points.ready = advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
			stride_q <= STRIDE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CURV_THRESHOLD: thresh_q <= cfg_data;
				REG_SAMPLE_STRIDE:  stride_q <= cfg_data[STRIDE_WIDTH-1:0];
				default:            thresh_q <= thresh_q;
			endcase
		end
	end

	// input decode: drop, fill or evaluate
	coord_t                  pt [AXES];
	logic [FILL_WIDTH-1:0]   fill_eff;
	logic [STRIDE_WIDTH-1:0] cnt_eff;
	logic [STRIDE_WIDTH-1:0] stride_eff;
	logic [STRIDE_WIDTH:0]   cnt_inc;
	logic [STRIDE_WIDTH-1:0] cnt_next;
	logic                    keep;
	logic                    full;
	logic                    eval;

	always_comb begin
		pt[0]      = points.point_x;
		pt[1]      = points.point_y;
		pt[2]      = points.point_z;
		fill_eff   = points.frame_start ? '0 : fill_q;
		cnt_eff    = points.frame_start ? '0 : cnt_q;
		keep       = points.point_valid &&
		             !(points.point_x == '0 && points.point_y == '0 && points.point_z == '0);
		full       = (fill_eff == FILL_FULL);
		eval       = keep && full && (cnt_eff == '0);
		stride_eff = (stride_q == '0) ? STRIDE_WIDTH'(1) : stride_q;
		cnt_inc    = {1'b0, cnt_eff} + (STRIDE_WIDTH+1)'(1);
		cnt_next   = (cnt_inc >= {1'b0, stride_eff}) ? '0 : cnt_inc[STRIDE_WIDTH-1:0];
	end

	// fill and stride counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			if (keep && !full) begin
				fill_q <= fill_eff + FILL_WIDTH'(1);
				cnt_q  <= cnt_eff;
			end else if (keep) begin
				fill_q <= fill_eff;
				cnt_q  <= cnt_next;
			end else begin
				fill_q <= fill_eff;
				cnt_q  <= cnt_eff;
			end
		end
	end

	// window: direct write while filling, shift once full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < WIN_DEPTH; e++) begin
				for (int a = 0; a < AXES; a++) win_q[a][e] <= '0;
				win_inten_q[e] <= '0;
			end
		end else if (accept && keep) begin
			for (int e = 0; e < WIN_DEPTH; e++) begin
				if (full) begin
					if (e == WIN_DEPTH - 1) begin
						for (int a = 0; a < AXES; a++) win_q[a][e] <= pt[a];
						win_inten_q[e] <= points.intensity;
					end else begin
						for (int a = 0; a < AXES; a++) win_q[a][e] <= win_q[a][e+1];
						win_inten_q[e] <= win_inten_q[e+1];
					end
				end else if (fill_eff[1:0] == 2'(e)) begin
					for (int a = 0; a < AXES; a++) win_q[a][e] <= pt[a];
					win_inten_q[e] <= points.intensity;
				end
			end
		end
	end

	// stage 1: second differences and centre point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept && eval;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int a = 0; a < AXES; a++) begin
				diff_s1[a]   <= second_diff(win_q[a][0], win_q[a][1], win_q[a][2],
				                            win_q[a][3], pt[a]);
				centre_s1[a] <= win_q[a][2];
			end
			inten_s1 <= win_inten_q[2];
		end
	end

	// stage 2: squared terms, forced past the limit on overflow
	logic [AW-1:0]         mag [AXES];
	logic [63:0]           mag_ext [AXES];
	logic [2*MW-1:0]       sq [AXES];
	logic [TERM_WIDTH-1:0] term [AXES];

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			mag[a]     = diff_s1[a][DW-1] ? AW'(-diff_s1[a]) : AW'(diff_s1[a]);
			mag_ext[a] = 64'(mag[a]);
			sq[a]      = mag[a][MW-1:0] * mag[a][MW-1:0];
			term[a]    = (mag_ext[a] >= (64'd1 << SQ_IN_MAX)) ?
			             {1'b1, {CURV_WIDTH{1'b0}}} : TERM_WIDTH'(sq[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			term_s2   <= term;
			centre_s2 <= centre_s1;
			inten_s2  <= inten_s1;
		end
	end

	// stage 3: sum, clamp and threshold compare
	logic [SUM_WIDTH-1:0]  sum;
	logic [CURV_WIDTH-1:0] curv;
	logic                  flat;

	always_comb begin
		sum  = SUM_WIDTH'(term_s2[0]) + SUM_WIDTH'(term_s2[1]) + SUM_WIDTH'(term_s2[2]);
		curv = (sum > SUM_WIDTH'(CURV_MAX)) ? CURV_MAX : sum[CURV_WIDTH-1:0];
		flat = curv < thresh_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s2 && flat;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_pt_q    <= centre_s2;
			out_inten_q <= inten_s2;
			out_curv_q  <= curv;
		end
	end

	assign features.valid             = out_valid_q;
	assign features.feature_x         = out_pt_q[0];
	assign features.feature_y         = out_pt_q[1];
	assign features.feature_z         = out_pt_q[2];
	assign features.feature_intensity = out_inten_q;
	assign features.curvature         = out_curv_q;

endmodule

### src/lfps_checker.sv
// ----------------------------------------------------------------------------
// lfps_checker
// Port-level checks of the flat point selector, bound to the top level.
// ----------------------------------------------------------------------------
module lfps_checker
	import lfps_pkg::*;
#(
	parameter int COORD_WIDTH = 24
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [COORD_WIDTH-1:0] out_x,
	input logic signed [COORD_WIDTH-1:0] out_y,
	input logic signed [COORD_WIDTH-1:0] out_z,
	input logic [INTEN_WIDTH-1:0]        out_inten,
	input logic [CURV_WIDTH-1:0]         out_curv
);

	// a stalled item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("feature item dropped while stalled");

	// a stalled item keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
			&& $stable(out_inten) && $stable(out_curv))
		else $error("feature payload changed while stalled");

	// with the output register empty the input side is never held off
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// points at the origin are dropped, so no feature sits there
	a_no_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_x == '0 && out_y == '0 && out_z == '0))
		else $error("feature at the origin");

endmodule

bind lidar_flat_point_selector lfps_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_lfps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (points.ready),
	.out_valid (features.valid),
	.out_ready (features.ready),
	.out_x     (features.feature_x),
	.out_y     (features.feature_y),
	.out_z     (features.feature_z),
	.out_inten (features.feature_intensity),
	.out_curv  (features.curvature)
);

### test/lfps_feature_checker.sv
// ----------------------------------------------------------------------------
// lfps_feature_checker
// Watches the point, feature and register ports of the flat point selector.
// It keeps its own five-point window and stride position, works out the
// flat features each accepted point should give, and checks every feature
// the block hands out against the oldest one still owed.
// ----------------------------------------------------------------------------
module lfps_feature_checker
	import lfps_pkg::*;
#(
	parameter int COORD_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_reg_t              cfg_index,
	input  logic [CURV_WIDTH-1:0] cfg_data,
	lfps_point_if                 points,
	lfps_feature_if               features,
	output int                    pending,
	output int                    fail_count
);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct {
		coord_t                 x;
		coord_t                 y;
		coord_t                 z;
		logic [INTEN_WIDTH-1:0] inten;
		logic [CURV_WIDTH-1:0]  curv;
	} flat_feature_t;

	// register shadows
	logic [CURV_WIDTH-1:0]   flat_limit;
	logic [STRIDE_WIDTH-1:0] stride_setting;

	// last four kept points, oldest first
	coord_t                 win_x[WIN_DEPTH];
	coord_t                 win_y[WIN_DEPTH];
	coord_t                 win_z[WIN_DEPTH];
	logic [INTEN_WIDTH-1:0] win_inten[WIN_DEPTH];
	int                     fill_level;
	int                     stride_pos;

	int            mismatches;
	flat_feature_t due;
	flat_feature_t flat_feature_q[$];

	// squared second difference of one axis; too large a difference is pushed past the limit
	function automatic longint unsigned axis_bend(coord_t w[WIN_DEPTH], coord_t newest);
		longint d;
		d = longint'(w[0]) + longint'(w[1]) - 4 * longint'(w[2]) + longint'(w[3])
			+ longint'(newest);
		if (d < 0)
			d = -d;
		if (d >= (longint'(1) << SQ_IN_MAX))
			return longint'(CURV_MAX) + 1;
		return longint'(d * d);
	endfunction

	// one accepted point through the window; queues the flat feature it gives, if any
	task automatic predict_flat_feature();
		coord_t                px;
		coord_t                py;
		coord_t                pz;
		logic [SUM_WIDTH-1:0]  bend;
		int                    eff_stride;
		flat_feature_t         owed;
		px = points.point_x;
		py = points.point_y;
		pz = points.point_z;
		if (points.frame_start) begin
			fill_level = 0;
			stride_pos = 0;
		end
		if (!points.point_valid || (px == 0 && py == 0 && pz == 0))
			return;
		// window still filling
		if (fill_level < WIN_DEPTH) begin
			win_x[fill_level]     = px;
			win_y[fill_level]     = py;
			win_z[fill_level]     = pz;
			win_inten[fill_level] = points.intensity;
			fill_level++;
			return;
		end
		// a zero stride acts as one
		eff_stride = (stride_setting == 0) ? 1 : int'(stride_setting);
		if (stride_pos == 0) begin
			bend = SUM_WIDTH'(axis_bend(win_x, px) + axis_bend(win_y, py) + axis_bend(win_z, pz));
			if (bend > CURV_MAX)
				bend = SUM_WIDTH'(CURV_MAX);
			if (bend < flat_limit) begin
				owed = '{win_x[2], win_y[2], win_z[2], win_inten[2], bend[CURV_WIDTH-1:0]};
				flat_feature_q = {flat_feature_q, owed};
			end
		end
		stride_pos++;
		if (stride_pos >= eff_stride)
			stride_pos = 0;
		// shift the new point in
		for (int i = 0; i < WIN_DEPTH - 1; i++) begin
			win_x[i]     = win_x[i+1];
			win_y[i]     = win_y[i+1];
			win_z[i]     = win_z[i+1];
			win_inten[i] = win_inten[i+1];
		end
		win_x[WIN_DEPTH-1]     = px;
		win_y[WIN_DEPTH-1]     = py;
		win_z[WIN_DEPTH-1]     = pz;
		win_inten[WIN_DEPTH-1] = points.intensity;
	endtask

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// predict on accepted points, compare on accepted features
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flat_limit     = THRESH_RESET;
			stride_setting = STRIDE_RESET;
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_x[i]     = '0;
				win_y[i]     = '0;
				win_z[i]     = '0;
				win_inten[i] = '0;
			end
			fill_level = 0;
			stride_pos = 0;
			mismatches = 0;
			flat_feature_q.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CURV_THRESHOLD: flat_limit = cfg_data;
					REG_SAMPLE_STRIDE:  stride_setting = cfg_data[STRIDE_WIDTH-1:0];
					default: ;
				endcase
			end
			if (points.valid && points.ready)
				predict_flat_feature();
			if (features.valid && features.ready) begin
				if (flat_feature_q.size() == 0) begin
					$display("%0t: feature (%0d, %0d, %0d) curvature %0d with none expected",
						$time, features.feature_x, features.feature_y, features.feature_z,
						features.curvature);
					mismatches++;
				end else begin
					due = flat_feature_q.pop_front();
					check_field("feature_x", due.x, features.feature_x);
					check_field("feature_y", due.y, features.feature_y);
					check_field("feature_z", due.z, features.feature_z);
					check_field("feature_intensity", due.inten, features.feature_intensity);
					check_field("curvature", due.curv, features.curvature);
				end
			end
			pending    <= flat_feature_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

### test/tb_lidar_flat_point_selector.sv
// ----------------------------------------------------------------------------
// tb_lidar_flat_point_selector
// Drives lidar points into the flat point selector: a directed opening on
// extreme coordinates, dropped points, short frames and extreme settings,
// then frames of mostly smooth lines with random noise over a series of
// threshold and stride settings. Both channels idle at random; a checker
// beside the block predicts and compares every flat feature.
// ----------------------------------------------------------------------------
module tb_lidar_flat_point_selector;
	import lfps_pkg::*;

	localparam int CW            = 24;
	localparam int COORD_MAX     = (1 << (CW - 1)) - 1;
	localparam int COORD_MIN     = -(1 << (CW - 1));
	localparam int BASE_SPAN     = COORD_MAX - (1 << 20);
	localparam int SETTLE_CYCLES = 8;     // three-stage pipeline plus margin
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 62;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t                 x;
		coord_t                 y;
		coord_t                 z;
		logic [INTEN_WIDTH-1:0] inten;
		logic                   pvalid;
		logic                   fstart;
	} lidar_point_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CURV_WIDTH-1:0] cfg_data;
	bit                    gaps_on;
	int                    pending;
	int                    fail_count;
	int                    points_sent;

	lfps_point_if   #(.COORD_WIDTH(CW)) point_ch ();
	lfps_feature_if #(.COORD_WIDTH(CW)) feature_ch ();

	lidar_flat_point_selector #(.COORD_WIDTH(CW)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.points    (point_ch),
		.features  (feature_ch)
	);

	lfps_feature_checker #(.COORD_WIDTH(CW)) feature_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.points     (point_ch),
		.features   (feature_ch),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// feature sink with random stall bursts
	initial begin
		feature_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 5) == 0) begin
				feature_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			feature_ch.ready <= 1'b1;
		end
	end

	// watchdog: too long without any item moving
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (point_ch.valid && point_ch.ready)
					|| (feature_ch.valid && feature_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_lidar_flat_point_selector: FAIL");
		$finish;
	end

	function automatic lidar_point_t mk_point(int x, int y, int z, int inten, bit pv, bit fs);
		lidar_point_t pt;
		pt.x      = coord_t'(x);
		pt.y      = coord_t'(y);
		pt.z      = coord_t'(z);
		pt.inten  = INTEN_WIDTH'(inten);
		pt.pvalid = pv;
		pt.fstart = fs;
		return pt;
	endfunction

	// one item on the point channel, after an occasional idle burst
	task automatic send_point(lidar_point_t pt);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			point_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		point_ch.valid       <= 1'b1;
		point_ch.point_x     <= pt.x;
		point_ch.point_y     <= pt.y;
		point_ch.point_z     <= pt.z;
		point_ch.intensity   <= pt.inten;
		point_ch.point_valid <= pt.pvalid;
		point_ch.frame_start <= pt.fstart;
		@(posedge clk);
		while (!point_ch.ready)
			@(posedge clk);
		points_sent++;
	endtask

	// stop sending, let every owed feature and the pipeline drain
	task automatic settle();
		point_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CURV_WIDTH-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// sharp spike frame: largest curvature the coordinates allow, with a dropped point inside
	task automatic send_spike_frame();
		send_point(mk_point(COORD_MIN, COORD_MIN, COORD_MIN, 16'h1111, 1'b1, 1'b1));
		send_point(mk_point(COORD_MIN, COORD_MIN, COORD_MIN, 16'h2222, 1'b1, 1'b0));
		send_point(mk_point(COORD_MAX, COORD_MAX, COORD_MAX, 16'hdead, 1'b0, 1'b0));
		send_point(mk_point(COORD_MAX, COORD_MAX, COORD_MAX, 16'h3333, 1'b1, 1'b0));
		send_point(mk_point(COORD_MIN, COORD_MIN, COORD_MIN, 16'h4444, 1'b1, 1'b0));
		send_point(mk_point(COORD_MIN, COORD_MIN, COORD_MIN, 16'h5555, 1'b1, 1'b0));
	endtask

	// random frame: mostly a noisy straight line, sometimes pure noise or a short frame
	task automatic send_frame();
		int           kind;
		int           len;
		int           amp;
		int           base[3];
		int           step[3];
		int           c[3];
		bit           keep_start;
		lidar_point_t pt;
		kind       = $urandom_range(0, 9);
		len        = (kind == 1) ? $urandom_range(1, 4) : $urandom_range(5, 40);
		amp        = $urandom_range(0, 5);
		amp        = (amp == 0) ? 0 : (1 << (amp - 1));
		keep_start = ($urandom_range(0, 7) != 0);
		for (int a = 0; a < 3; a++) begin
			base[a] = int'($urandom_range(0, 2 * BASE_SPAN)) - BASE_SPAN;
			step[a] = int'($urandom_range(0, 8192)) - 4096;
		end
		for (int i = 0; i < len; i++) begin
			for (int a = 0; a < 3; a++) begin
				if (kind == 0)
					c[a] = int'($urandom);
				else
					c[a] = base[a] + i * step[a] + int'($urandom_range(0, 2 * amp)) - amp;
			end
			// stray points at the origin
			if ($urandom_range(0, 39) == 0)
				c = '{0, 0, 0};
			pt = mk_point(c[0], c[1], c[2], int'($urandom_range(0, 65535)),
				$urandom_range(0, 24) != 0, (i == 0) && keep_start);
			send_point(pt);
		end
	endtask

	initial begin : stimulus
		int phase_end;
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= REG_CURV_THRESHOLD;
		cfg_data             <= '0;
		gaps_on              <= 1'b1;
		point_ch.valid       <= 1'b0;
		point_ch.point_x     <= '0;
		point_ch.point_y     <= '0;
		point_ch.point_z     <= '0;
		point_ch.intensity   <= '0;
		point_ch.point_valid <= 1'b0;
		point_ch.frame_start <= 1'b0;
		points_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: frame start on a dropped point, then a valid origin point
		send_point(mk_point(COORD_MAX, COORD_MIN, 1, 16'hffff, 1'b0, 1'b1));
		send_point(mk_point(0, 0, 0, 16'h0001, 1'b1, 1'b0));
		// flat runs at both coordinate extremes
		for (int i = 0; i < 7; i++)
			send_point(mk_point(COORD_MAX, COORD_MAX, COORD_MAX, (i == 2) ? 16'hffff : i,
				1'b1, 1'b0));
		for (int i = 0; i < 5; i++)
			send_point(mk_point(COORD_MIN, COORD_MIN, COORD_MIN, 16'h0000, 1'b1, i == 0));
		// short frame gives nothing
		for (int i = 0; i < 3; i++)
			send_point(mk_point(i + 1, -i - 1, 2 * i + 1, 16'h00ff, 1'b1, i == 0));
		send_spike_frame();
		settle();

		// widest threshold, zero stride
		write_reg(REG_CURV_THRESHOLD, CURV_MAX);
		write_reg(REG_SAMPLE_STRIDE, '0);
		send_spike_frame();
		settle();

		// random phases over a spread of settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					write_reg(REG_CURV_THRESHOLD, THRESH_RESET);
					write_reg(REG_SAMPLE_STRIDE, CURV_WIDTH'(STRIDE_RESET));
				end
				1: begin
					write_reg(REG_CURV_THRESHOLD, '0);
					write_reg(REG_SAMPLE_STRIDE, CURV_WIDTH'(1));
				end
				2: begin
					write_reg(REG_CURV_THRESHOLD, CURV_WIDTH'($urandom_range(0, 100000)));
					write_reg(REG_SAMPLE_STRIDE, CURV_WIDTH'(2));
				end
				3: begin
					write_reg(REG_CURV_THRESHOLD, CURV_MAX);
					write_reg(REG_SAMPLE_STRIDE, CURV_WIDTH'(255));
				end
				4: begin
					write_reg(REG_CURV_THRESHOLD, CURV_WIDTH'($urandom_range(0, 100000)));
					write_reg(REG_SAMPLE_STRIDE, CURV_WIDTH'($urandom_range(1, 8)));
				end
				5: begin
					write_reg(REG_CURV_THRESHOLD, CURV_WIDTH'({$urandom, $urandom}));
					write_reg(REG_SAMPLE_STRIDE, CURV_WIDTH'(3));
				end
				6: begin
					write_reg(REG_CURV_THRESHOLD, CURV_WIDTH'(1) << 20);
					write_reg(REG_SAMPLE_STRIDE, CURV_WIDTH'(1));
				end
				7: begin
					write_reg(REG_CURV_THRESHOLD, CURV_WIDTH'($urandom_range(0, 20000)));
					write_reg(REG_SAMPLE_STRIDE, '0);
				end
				8: begin
					write_reg(REG_CURV_THRESHOLD, CURV_WIDTH'($urandom_range(500, 50000)));
					write_reg(REG_SAMPLE_STRIDE, CURV_WIDTH'(1));
				end
				default: begin
					write_reg(REG_CURV_THRESHOLD, CURV_MAX);
					write_reg(REG_SAMPLE_STRIDE, CURV_WIDTH'(2));
				end
			endcase
			// one phase runs without idling; the last two run at full rate
			gaps_on <= (p != 4) && (p < PHASES - 2);
			phase_end = points_sent + PHASE_ITEMS;
			while (points_sent < phase_end)
				send_frame();
			settle();
		end

		if (fail_count == 0)
			$display("tb_lidar_flat_point_selector: PASS");
		else
			$display("tb_lidar_flat_point_selector: FAIL");
		$finish;
	end

endmodule

### files.f
src/lfps_pkg.sv
src/lfps_point_if.sv
src/lidar_flat_point_selector.sv
src/lfps_checker.sv
test/lfps_feature_checker.sv
test/tb_lidar_flat_point_selector.sv
